// ===== rtl/bctp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bctp_pkg
// Shared constants, codes and types of the basis change triple product unit.
// -----------------------------------------------------------------------------
package bctp_pkg;

  localparam int MAX_BASIS   = 64;
  localparam int MAX_BANDS   = 128;
  localparam int MAX_OUT_DIM = 64;

  localparam int BASIS_W = $clog2(MAX_BASIS);
  localparam int BAND_W  = $clog2(MAX_BANDS);
  localparam int OUT_W   = $clog2(MAX_OUT_DIM);
  localparam int CNT_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 7;
  localparam int VAL_W   = 32;
  localparam int RES_W   = 48;
  localparam int PROD_W  = 64;
  localparam int ACC_W   = 56;

  localparam int COEF_DEPTH  = MAX_BANDS * MAX_BASIS;
  localparam int BASIS_DEPTH = MAX_BASIS * MAX_BASIS;
  localparam int RES_DEPTH   = MAX_OUT_DIM * MAX_OUT_DIM;
  localparam int CLR_W       = $clog2(RES_DEPTH);

  localparam int DRAIN_CYC = 5;
  localparam int DRAIN_W   = 3;

  localparam logic RESP_STATUS = 1'b0;
  localparam logic RESP_READ   = 1'b1;

  typedef enum logic [1:0] {
    REQ_LOAD_C  = 2'd0,
    REQ_LOAD_V  = 2'd1,
    REQ_COMPUTE = 2'd2,
    REQ_READ    = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASIS_COUNT   = 3'd0,
    CFG_FIRST_COUNT   = 3'd1,
    CFG_SECOND_COUNT  = 3'd2,
    CFG_FIRST_OFFSET  = 3'd3,
    CFG_SECOND_OFFSET = 3'd4,
    CFG_ACCUMULATE    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0] basis_count;
    logic [CNT_W-1:0] first_count;
    logic [CNT_W-1:0] second_count;
    logic [BAND_W-1:0] first_offset;
    logic [BAND_W-1:0] second_offset;
    logic              accumulate;
    logic              valid;
  } cfg_t;

  typedef struct packed {
    logic               clear;
    logic [CLR_W-1:0]   clr_addr;
    logic               issue;
    logic               phase_b;
    logic [OUT_W-1:0]   p;
    logic [BASIS_W-1:0] j;
    logic [BASIS_W-1:0] k;
    logic               first;
    logic               last;
    logic               done;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic               phase_b;
    logic               first;
    logic               last;
    logic [OUT_W-1:0]   p;
    logic [BASIS_W-1:0] j;
  } tag_t;

endpackage
`default_nettype wire

// ===== rtl/bctp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bctp_ram
// Generic single write port, single read port RAM with registered read data.
// -----------------------------------------------------------------------------
module bctp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/bctp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bctp_cfg
// Configuration registers and the compute settings check.
// -----------------------------------------------------------------------------
module bctp_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  input  wire logic [bctp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [bctp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                                    cfg_ready_o,
  output bctp_pkg::cfg_t                          cfg_o
);

  logic [bctp_pkg::CNT_W-1:0]  nb_q, n1_q, n2_q;
  logic [bctp_pkg::BAND_W-1:0] o1_q, o2_q;
  logic                        acc_q;
  logic [bctp_pkg::CNT_W:0]    end1, end2;
  logic                        ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q  <= bctp_pkg::CNT_W'(bctp_pkg::MAX_BASIS);
      n1_q  <= bctp_pkg::CNT_W'(1);
      n2_q  <= bctp_pkg::CNT_W'(1);
      o1_q  <= '0;
      o2_q  <= '0;
      acc_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (bctp_pkg::cfg_idx_e'(cfg_index_i))
        bctp_pkg::CFG_BASIS_COUNT:   nb_q  <= cfg_data_i[bctp_pkg::CNT_W-1:0];
        bctp_pkg::CFG_FIRST_COUNT:   n1_q  <= cfg_data_i[bctp_pkg::CNT_W-1:0];
        bctp_pkg::CFG_SECOND_COUNT:  n2_q  <= cfg_data_i[bctp_pkg::CNT_W-1:0];
        bctp_pkg::CFG_FIRST_OFFSET:  o1_q  <= cfg_data_i[bctp_pkg::BAND_W-1:0];
        bctp_pkg::CFG_SECOND_OFFSET: o2_q  <= cfg_data_i[bctp_pkg::BAND_W-1:0];
        bctp_pkg::CFG_ACCUMULATE:    acc_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    end1 = {1'b0, o1_q} + {1'b0, n1_q};
    end2 = {1'b0, o2_q} + {1'b0, n2_q};
    ok = (nb_q != '0) && (nb_q <= bctp_pkg::CNT_W'(bctp_pkg::MAX_BASIS))
      && (n1_q != '0) && (n1_q <= bctp_pkg::CNT_W'(bctp_pkg::MAX_OUT_DIM))
      && (n2_q != '0) && (n2_q <= bctp_pkg::CNT_W'(bctp_pkg::MAX_OUT_DIM))
      && (end1 <= (bctp_pkg::CNT_W+1)'(bctp_pkg::MAX_BANDS))
      && (end2 <= (bctp_pkg::CNT_W+1)'(bctp_pkg::MAX_BANDS));
  end

  assign cfg_ready_o         = 1'b1;
  assign cfg_o.basis_count   = nb_q;
  assign cfg_o.first_count   = n1_q;
  assign cfg_o.second_count  = n2_q;
  assign cfg_o.first_offset  = o1_q;
  assign cfg_o.second_offset = o2_q;
  assign cfg_o.accumulate    = acc_q;
  assign cfg_o.valid         = ok;

endmodule
`default_nettype wire

// ===== rtl/bctp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bctp_ctrl
// Sequencer: result clear after reset and the multiply-accumulate passes.
// -----------------------------------------------------------------------------
module bctp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [1:0]     req_type_i,
  input  bctp_pkg::cfg_t      cfg_i,
  output logic                busy_o,
  output bctp_pkg::cmd_t      cmd_o
);

  bctp_pkg::state_e state_q, state_d;
  logic [bctp_pkg::CLR_W-1:0]   clr_q;
  logic [bctp_pkg::BASIS_W-1:0] k_q, j_q;
  logic [bctp_pkg::OUT_W-1:0]   p_q;
  logic                         phase_q;
  logic [bctp_pkg::DRAIN_W-1:0] drain_q;

  logic [bctp_pkg::BASIS_W-1:0] nb_last;
  logic [bctp_pkg::OUT_W-1:0]   n1_last, n2_last;
  logic go, k_end, drain_end, j_end, final_pass, clr_end;

  always_comb begin
    nb_last    = bctp_pkg::BASIS_W'(cfg_i.basis_count - 7'd1);
    n1_last    = bctp_pkg::OUT_W'(cfg_i.first_count - 7'd1);
    n2_last    = bctp_pkg::OUT_W'(cfg_i.second_count - 7'd1);
    go         = accept_i && (req_type_i == bctp_pkg::REQ_COMPUTE) && cfg_i.valid;
    k_end      = (k_q == nb_last);
    drain_end  = (drain_q == bctp_pkg::DRAIN_W'(bctp_pkg::DRAIN_CYC - 1));
    j_end      = phase_q ? (j_q == bctp_pkg::BASIS_W'(n2_last)) : (j_q == nb_last);
    final_pass = phase_q && j_end && (p_q == n1_last);
    clr_end    = (clr_q == {bctp_pkg::CLR_W{1'b1}});
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bctp_pkg::ST_CLEAR: if (clr_end) state_d = bctp_pkg::ST_IDLE;
      bctp_pkg::ST_IDLE:  if (go) state_d = bctp_pkg::ST_ISSUE;
      bctp_pkg::ST_ISSUE: if (k_end) state_d = bctp_pkg::ST_DRAIN;
      bctp_pkg::ST_DRAIN: begin
        if (drain_end) state_d = final_pass ? bctp_pkg::ST_IDLE : bctp_pkg::ST_ISSUE;
      end
      default: state_d = bctp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bctp_pkg::ST_CLEAR;
      clr_q   <= '0;
      k_q     <= '0;
      j_q     <= '0;
      p_q     <= '0;
      phase_q <= 1'b0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        bctp_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
        bctp_pkg::ST_IDLE: begin
          k_q     <= '0;
          j_q     <= '0;
          p_q     <= '0;
          phase_q <= 1'b0;
          drain_q <= '0;
        end
        bctp_pkg::ST_ISSUE: begin
          k_q <= k_end ? '0 : k_q + 1'b1;
        end
        bctp_pkg::ST_DRAIN: begin
          drain_q <= drain_end ? '0 : drain_q + 1'b1;
          if (drain_end) begin
            if (!j_end) begin
              j_q <= j_q + 1'b1;
            end else if (!phase_q) begin
              j_q     <= '0;
              phase_q <= 1'b1;
            end else begin
              j_q     <= '0;
              phase_q <= 1'b0;
              p_q     <= p_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.clr_addr = clr_q;
    cmd_o.phase_b  = phase_q;
    cmd_o.p        = p_q;
    cmd_o.j        = j_q;
    cmd_o.k        = k_q;
    cmd_o.first    = (k_q == '0);
    cmd_o.last     = k_end;
    busy_o         = 1'b1;
    case (state_q)
      bctp_pkg::ST_CLEAR: cmd_o.clear = 1'b1;
      bctp_pkg::ST_IDLE:  busy_o = 1'b0;
      bctp_pkg::ST_ISSUE: cmd_o.issue = 1'b1;
      bctp_pkg::ST_DRAIN: cmd_o.done = drain_end && final_pass;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bctp_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bctp_dp
// Datapath: the four stores, multiply, round, accumulate, saturate, responses.
// -----------------------------------------------------------------------------
module bctp_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  bctp_pkg::cmd_t                         cmd_i,
  input  bctp_pkg::cfg_t                         cfg_i,
  input  wire logic                              accept_i,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic [bctp_pkg::BAND_W-1:0]       row_index_i,
  input  wire logic [bctp_pkg::BASIS_W-1:0]      col_index_i,
  input  wire logic signed [bctp_pkg::VAL_W-1:0] element_value_i,
  output logic                                   resp_valid_o,
  output logic                                   resp_kind_o,
  output logic                                   error_flag_o,
  output logic signed [bctp_pkg::RES_W-1:0]      result_value_o
);

  localparam logic signed [bctp_pkg::ACC_W-1:0] S32_MAX =
    bctp_pkg::ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [bctp_pkg::ACC_W-1:0] S32_MIN = -S32_MAX - 1;
  localparam logic signed [bctp_pkg::ACC_W-1:0] S48_MAX =
    bctp_pkg::ACC_W'(64'sh7FFF_FFFF_FFFF);
  localparam logic signed [bctp_pkg::ACC_W-1:0] S48_MIN = -S48_MAX - 1;
  localparam logic signed [bctp_pkg::RES_W:0] R48_MAX =
    (bctp_pkg::RES_W+1)'(64'sh7FFF_FFFF_FFFF);
  localparam logic signed [bctp_pkg::RES_W:0] R48_MIN = -R48_MAX - 1;

  logic is_ld_c, is_ld_v, is_read, is_comp;
  logic signed [bctp_pkg::VAL_W-1:0] coef_rd, basis_rd, trow_rd;
  logic [bctp_pkg::RES_W-1:0] res_rd;
  logic [bctp_pkg::BAND_W-1:0] c_row;
  logic res_re, res_we;
  logic [bctp_pkg::CLR_W-1:0] res_raddr, res_waddr;
  logic [bctp_pkg::RES_W-1:0] res_wdata;

  bctp_pkg::tag_t tag0, tag4, s1_q, s2_q, s3_q, s4_q;
  logic signed [bctp_pkg::PROD_W-1:0] prod_q, rnd_full;
  logic signed [bctp_pkg::VAL_W-1:0]  op_a, op_b;
  logic signed [bctp_pkg::ACC_W-1:0]  acc_q, rnd;
  logic signed [bctp_pkg::RES_W-1:0]  v_q, v_d, new_val;
  logic signed [bctp_pkg::RES_W:0]    sum49;

  logic rv_q, rk_q, re_q;

  always_comb begin
    is_ld_c = accept_i && (req_type_i == bctp_pkg::REQ_LOAD_C);
    is_ld_v = accept_i && (req_type_i == bctp_pkg::REQ_LOAD_V)
      && ({1'b0, row_index_i} < (bctp_pkg::BAND_W+1)'(bctp_pkg::MAX_BASIS));
    is_read = accept_i && (req_type_i == bctp_pkg::REQ_READ);
    is_comp = accept_i && (req_type_i == bctp_pkg::REQ_COMPUTE);
    c_row   = (cmd_i.phase_b ? cfg_i.second_offset : cfg_i.first_offset)
      + (cmd_i.phase_b ? bctp_pkg::BAND_W'(cmd_i.j) : bctp_pkg::BAND_W'(cmd_i.p));
  end

  bctp_ram #(.WIDTH(bctp_pkg::VAL_W), .DEPTH(bctp_pkg::COEF_DEPTH)) u_coef (
    .clk_i   (clk_i),
    .we_i    (is_ld_c),
    .waddr_i ({row_index_i, col_index_i}),
    .wdata_i (element_value_i),
    .re_i    (cmd_i.issue),
    .raddr_i ({c_row, cmd_i.k}),
    .rdata_o (coef_rd)
  );

  bctp_ram #(.WIDTH(bctp_pkg::VAL_W), .DEPTH(bctp_pkg::BASIS_DEPTH)) u_basis (
    .clk_i   (clk_i),
    .we_i    (is_ld_v),
    .waddr_i ({row_index_i[bctp_pkg::BASIS_W-1:0], col_index_i}),
    .wdata_i (element_value_i),
    .re_i    (cmd_i.issue),
    .raddr_i ({cmd_i.k, cmd_i.j}),
    .rdata_o (basis_rd)
  );

  bctp_ram #(.WIDTH(bctp_pkg::VAL_W), .DEPTH(bctp_pkg::MAX_BASIS)) u_trow (
    .clk_i   (clk_i),
    .we_i    (s4_q.valid && !s4_q.phase_b),
    .waddr_i (s4_q.j),
    .wdata_i (v_q[bctp_pkg::VAL_W-1:0]),
    .re_i    (cmd_i.issue),
    .raddr_i (cmd_i.k),
    .rdata_o (trow_rd)
  );

  always_comb begin
    res_re    = is_read || (cmd_i.issue && cmd_i.phase_b && cmd_i.first);
    res_raddr = is_read ? {row_index_i[bctp_pkg::OUT_W-1:0], col_index_i}
                        : {cmd_i.p, cmd_i.j};
    sum49     = {res_rd[bctp_pkg::RES_W-1], res_rd} + {v_q[bctp_pkg::RES_W-1], v_q};
    if (sum49 > R48_MAX) begin
      new_val = R48_MAX[bctp_pkg::RES_W-1:0];
    end else if (sum49 < R48_MIN) begin
      new_val = R48_MIN[bctp_pkg::RES_W-1:0];
    end else begin
      new_val = sum49[bctp_pkg::RES_W-1:0];
    end
    if (!cfg_i.accumulate) new_val = v_q;
    res_we    = cmd_i.clear || (s4_q.valid && s4_q.phase_b);
    res_waddr = cmd_i.clear ? cmd_i.clr_addr : {s4_q.p, s4_q.j};
    res_wdata = cmd_i.clear ? '0 : new_val;
  end

  bctp_ram #(.WIDTH(bctp_pkg::RES_W), .DEPTH(bctp_pkg::RES_DEPTH)) u_res (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (res_waddr),
    .wdata_i (res_wdata),
    .re_i    (res_re),
    .raddr_i (res_raddr),
    .rdata_o (res_rd)
  );

  always_comb begin
    tag0.valid   = cmd_i.issue;
    tag0.phase_b = cmd_i.phase_b;
    tag0.first   = cmd_i.first;
    tag0.last    = cmd_i.last;
    tag0.p       = cmd_i.p;
    tag0.j       = cmd_i.j;
    tag4         = s3_q;
    tag4.valid   = s3_q.valid && s3_q.last;
    op_a     = s1_q.phase_b ? trow_rd : coef_rd;
    op_b     = s1_q.phase_b ? coef_rd : basis_rd;
    rnd_full = (prod_q + 64'sd32768) >>> 16;
    rnd      = rnd_full[bctp_pkg::ACC_W-1:0];
    if (s3_q.phase_b) begin
      if (acc_q > S48_MAX)      v_d = S48_MAX[bctp_pkg::RES_W-1:0];
      else if (acc_q < S48_MIN) v_d = S48_MIN[bctp_pkg::RES_W-1:0];
      else                      v_d = acc_q[bctp_pkg::RES_W-1:0];
    end else begin
      if (acc_q > S32_MAX)      v_d = S32_MAX[bctp_pkg::RES_W-1:0];
      else if (acc_q < S32_MIN) v_d = S32_MIN[bctp_pkg::RES_W-1:0];
      else                      v_d = acc_q[bctp_pkg::RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
      rv_q <= 1'b0;
      rk_q <= 1'b0;
      re_q <= 1'b0;
    end else begin
      s1_q <= tag0;
      s2_q <= s1_q;
      s3_q <= s2_q;
      s4_q <= tag4;
      rv_q <= is_read || (is_comp && !cfg_i.valid) || cmd_i.done;
      rk_q <= is_read ? bctp_pkg::RESP_READ : bctp_pkg::RESP_STATUS;
      re_q <= is_read ? ({1'b0, row_index_i} >= (bctp_pkg::BAND_W+1)'(bctp_pkg::MAX_OUT_DIM))
                      : (is_comp && !cfg_i.valid);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    if (s2_q.valid) begin
      acc_q <= s2_q.first ? rnd : acc_q + rnd;
    end
    v_q <= v_d;
  end

  assign resp_valid_o   = rv_q;
  assign resp_kind_o    = rk_q;
  assign error_flag_o   = re_q;
  assign result_value_o = (rk_q == bctp_pkg::RESP_READ && !re_q) ? res_rd : '0;

endmodule
`default_nettype wire

// ===== rtl/basis_change_triple_product_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// basis_change_triple_product_unit
// Forms R = C1 * V * C2^T over a stored coefficient and basis matrix.
// -----------------------------------------------------------------------------
// Request channel: an item is taken when start is high and busy is low.
// Loads of C and V give no response; a load every cycle is sustained.
// A read gives one response the cycle after it is taken
// and reads may also follow each other every cycle.
// A compute with bad settings answers with error_flag_o the next cycle.
// A good compute holds busy high while the single multiply-accumulate unit,
// fed from one coefficient port, works through its passes,
// then gives its status response; the result store is written in place.
// Responses show for one cycle under resp_valid_o; there is no back pressure.
// Configuration writes (cfg_valid_i, cfg_ready_o always high) land at once;
// the user must keep them to idle periods, as the block does not enforce it.
// After reset the result store, all 4096 entries, is zeroed with busy high.
// -----------------------------------------------------------------------------
module basis_change_triple_product_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           req_type_i,
  input  wire logic [bctp_pkg::BAND_W-1:0]          row_index_i,
  input  wire logic [bctp_pkg::BASIS_W-1:0]         col_index_i,
  input  wire logic signed [bctp_pkg::VAL_W-1:0]    element_value_i,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [bctp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [bctp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                      resp_valid_o,
  output logic                                      resp_kind_o,
  output logic                                      error_flag_o,
  output logic signed [bctp_pkg::RES_W-1:0]         result_value_o
);

  bctp_pkg::cfg_t cfg;
  bctp_pkg::cmd_t cmd;
  logic accept;

  assign accept = start && !busy;

  bctp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  bctp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .cfg_i      (cfg),
    .busy_o     (busy),
    .cmd_o      (cmd)
  );

  bctp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_i           (cfg),
    .accept_i        (accept),
    .req_type_i      (req_type_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .resp_valid_o    (resp_valid_o),
    .resp_kind_o     (resp_kind_o),
    .error_flag_o    (error_flag_o),
    .result_value_o  (result_value_o)
  );

endmodule
`default_nettype wire

// ===== rtl/bctp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bctp_checker
// Port level checks of the triple product unit, bound to the top level.
// -----------------------------------------------------------------------------
module bctp_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic [1:0]                      req_type_i,
  input wire logic [bctp_pkg::BAND_W-1:0]     row_index_i,
  input wire logic                            resp_valid_o,
  input wire logic                            resp_kind_o,
  input wire logic                            error_flag_o,
  input wire logic [bctp_pkg::RES_W-1:0]      result_value_o
);

  logic rd_acc;
  assign rd_acc = start && !busy && (req_type_i == bctp_pkg::REQ_READ);

  a_read_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc |=> resp_valid_o && (resp_kind_o == bctp_pkg::RESP_READ))
    else $error("read item without read response");

  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc && row_index_i[bctp_pkg::BAND_W-1] |=> error_flag_o)
    else $error("out of range read not flagged");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o && error_flag_o |-> (result_value_o == '0))
    else $error("error response carries data");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o && (resp_kind_o == bctp_pkg::RESP_STATUS) |-> (result_value_o == '0))
    else $error("status response carries data");

endmodule

bind basis_change_triple_product_unit bctp_checker u_bctp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_type_i     (req_type_i),
  .row_index_i    (row_index_i),
  .resp_valid_o   (resp_valid_o),
  .resp_kind_o    (resp_kind_o),
  .error_flag_o   (error_flag_o),
  .result_value_o (result_value_o)
);
`default_nettype wire
